// ----- hw/rtl/swm_pkg.sv -----
// Shared constants and types for the sliding window median filter.
package swm_pkg;

	localparam int WINDOW_MAX_DEF   = 32;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CFG_WIDTH        = 6;

	localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RST = 6'd3;

	// Per-cell flags seen by the neighbours and the eviction selector
	typedef struct packed {
		logic del;    // this cell holds the oldest entry and leaves the window
		logic shift;  // this cell sits at or right of the evicted entry
		logic above;  // this cell is empty or holds a value above the new sample
	} cell_flags_t;

endpackage

// ----- hw/rtl/swm_ifs.sv -----
// Valid/ready channel interfaces for samples, results and the window size setting.
interface swm_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [SAMPLE_WIDTH:0] twice_median;

	modport source (output valid, output twice_median, input ready);
	modport sink   (input valid, input twice_median, output ready);
endinterface

interface swm_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink   (input valid, input window_size, output ready);
endinterface

// ----- hw/rtl/swm_cell.sv -----
// One cell of the sorted window: holds a value and its age, evicts and inserts in place.
module swm_cell #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int AGE_W        = 5
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           evict,
	input  logic                           valid,
	input  logic [AGE_W-1:0]               oldest_age,
	input  logic signed [SAMPLE_WIDTH-1:0] ev_val,
	input  logic [AGE_W-1:0]               ev_age,
	input  logic signed [SAMPLE_WIDTH-1:0] left_val,
	input  logic [AGE_W-1:0]               left_age,
	input  swm_pkg::cell_flags_t           left_fl,
	input  logic signed [SAMPLE_WIDTH-1:0] right_val,
	input  logic [AGE_W-1:0]               right_age,
	input  swm_pkg::cell_flags_t           right_fl,
	output logic signed [SAMPLE_WIDTH-1:0] val_q,
	output logic [AGE_W-1:0]               age_q,
	output swm_pkg::cell_flags_t           fl
);
	import swm_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] e_val;
	logic [AGE_W-1:0]               e_age;
	logic                           e_above;
	logic signed [SAMPLE_WIDTH-1:0] l_val;
	logic [AGE_W-1:0]               l_age;
	logic                           l_above;

	// Classify against the evicted entry (value, then older first) and the new sample
	always_comb begin
		fl.del   = evict && valid && (age_q == oldest_age);
		fl.shift = fl.del || (evict && valid &&
			((val_q > ev_val) || ((val_q == ev_val) && (age_q < ev_age))));
		fl.above = !valid || (val_q > sample);
	end

	// Window after eviction, at this place and the place to the left
	always_comb begin
		e_val   = fl.shift ? right_val : val_q;
		e_age   = fl.shift ? right_age : age_q;
		e_above = fl.shift ? right_fl.above : fl.above;
		l_val   = left_fl.shift ? val_q : left_val;
		l_age   = left_fl.shift ? age_q : left_age;
		l_above = left_fl.shift ? fl.above : left_fl.above;
	end

	// Keep, take the new sample, or take the left neighbour; age every kept entry
	always_ff @(posedge clk) begin
		if (en) begin
			if (!e_above) begin
				val_q <= e_val;
				age_q <= e_age + AGE_W'(1);
			end else if (!l_above) begin
				val_q <= sample;
				age_q <= '0;
			end else begin
				val_q <= l_val;
				age_q <= l_age + AGE_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/swm_pick.sv -----
// Output stage: selects the two middle cells, adds them and holds the result.
module swm_pick #(
	parameter int WINDOW_MAX   = 32,
	parameter int SAMPLE_WIDTH = 16,
	parameter int CNT_W        = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [SAMPLE_WIDTH-1:0] vals [WINDOW_MAX],
	input  logic [CNT_W-1:0]               n_eff,
	input  logic                           load,
	input  logic                           out_ready,
	output logic                           load_ok,
	output logic                           out_valid,
	output logic signed [SAMPLE_WIDTH:0]   out_data
);
	import swm_pkg::*;

	logic [CNT_W-1:0]               lo_idx;
	logic [CNT_W-1:0]               hi_idx;
	logic signed [SAMPLE_WIDTH-1:0] lo_val;
	logic signed [SAMPLE_WIDTH-1:0] hi_val;
	logic signed [SAMPLE_WIDTH:0]   sum;
	logic                           valid_q;
	logic signed [SAMPLE_WIDTH:0]   data_q;

	// Select the two middle entries by position
	always_comb begin
		lo_idx = (n_eff - CNT_W'(1)) >> 1;
		hi_idx = n_eff >> 1;
		lo_val = '0;
		hi_val = '0;
		for (int k = 0; k < WINDOW_MAX; k++) begin
			if (lo_idx == CNT_W'(k)) lo_val = lo_val | vals[k];
			if (hi_idx == CNT_W'(k)) hi_val = hi_val | vals[k];
		end
		sum = {lo_val[SAMPLE_WIDTH-1], lo_val} + {hi_val[SAMPLE_WIDTH-1], hi_val};
	end

	assign load_ok = !valid_q || out_ready;

	// Hold the result until the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= sum;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- hw/rtl/sliding_window_median.sv -----
// Top level of the sliding window median filter: cell chain, fill control and output stage.
//
//  channel   dir  payload                 handshake
//  setup     in   window_size [5:0]       valid/ready, always ready, empties the window
//  samples   in   sample [SW-1:0] signed  valid/ready
//  medians   out  twice_median [SW:0]     valid/ready, one per sample once window is full
//
// A sample updates the whole cell chain in the cycle it is accepted and marks a result
// owed; once the output register can load, the two middle cells are added into it. One
// sample per cycle is taken while the output register drains; a result held there blocks
// input only once a second result is owed, and then until the held request is taken.
// Reset leaves the window empty with size three.
module sliding_window_median #(
	parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	swm_cfg_if.sink             setup,
	swm_sample_if.sink          samples,
	swm_median_if.source        medians
);
	import swm_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [CFG_WIDTH-1:0]           ws_q;
	logic [CNT_W-1:0]               fill_q;
	logic                           pend_q;
	logic [CNT_W-1:0]               n_eff;
	logic [AGE_W-1:0]               oldest_age;
	logic                           evict;
	logic                           accept;
	logic                           fires;
	logic                           load_ok;
	logic                           out_load;
	logic signed [SAMPLE_WIDTH-1:0] ev_val;
	logic [AGE_W-1:0]               ev_age;
	logic [WINDOW_MAX-1:0]          del_vec;
	logic signed [SAMPLE_WIDTH-1:0] val_a [WINDOW_MAX];
	logic [AGE_W-1:0]               age_a [WINDOW_MAX];
	cell_flags_t                    fl_a  [WINDOW_MAX];

	// Clamp the window size to the range the chain supports
	always_comb begin
		if (ws_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(ws_q) > WINDOW_MAX) begin
			n_eff = CNT_W'(WINDOW_MAX);
		end else begin
			n_eff = CNT_W'(ws_q);
		end
		oldest_age = AGE_W'(n_eff - CNT_W'(1));
	end

	assign evict    = (fill_q == n_eff);
	assign accept   = samples.valid && samples.ready;
	assign fires    = evict || ((fill_q + CNT_W'(1)) == n_eff);
	assign out_load = pend_q && load_ok;

	assign samples.ready = !pend_q || load_ok;
	assign setup.ready   = 1'b1;

	// Window size register and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= WINDOW_SIZE_RST;
			fill_q <= '0;
		end else if (setup.valid) begin
			ws_q   <= setup.window_size;
			fill_q <= '0;
		end else if (accept && !evict) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	// Mark a result owed to the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= fires;
		end else if (out_load) begin
			pend_q <= 1'b0;
		end
	end

	// Fetch the entry that leaves the window
	always_comb begin
		ev_val = '0;
		ev_age = '0;
		for (int k = 0; k < WINDOW_MAX; k++) begin
			del_vec[k] = fl_a[k].del;
			if (fl_a[k].del) begin
				ev_val = ev_val | val_a[k];
				ev_age = ev_age | age_a[k];
			end
		end
	end

	// Chain of cells, each wired to both neighbours
	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] l_val;
		logic [AGE_W-1:0]               l_age;
		cell_flags_t                    l_fl;
		logic signed [SAMPLE_WIDTH-1:0] r_val;
		logic [AGE_W-1:0]               r_age;
		cell_flags_t                    r_fl;
		logic                           valid;

		if (k == 0) begin : g_first
			assign l_val = '0;
			assign l_age = '0;
			assign l_fl  = '{del: 1'b0, shift: 1'b0, above: 1'b0};
		end else begin : g_mid_l
			assign l_val = val_a[k-1];
			assign l_age = age_a[k-1];
			assign l_fl  = fl_a[k-1];
		end

		if (k == WINDOW_MAX - 1) begin : g_last
			assign r_val = '0;
			assign r_age = '0;
			assign r_fl  = '{del: 1'b0, shift: 1'b0, above: 1'b1};
		end else begin : g_mid_r
			assign r_val = val_a[k+1];
			assign r_age = age_a[k+1];
			assign r_fl  = fl_a[k+1];
		end

		assign valid = (CNT_W'(k) < fill_q);

		swm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.AGE_W        (AGE_W)
		) u_cell (
			.clk        (clk),
			.en         (accept),
			.sample     (samples.sample),
			.evict      (evict),
			.valid      (valid),
			.oldest_age (oldest_age),
			.ev_val     (ev_val),
			.ev_age     (ev_age),
			.left_val   (l_val),
			.left_age   (l_age),
			.left_fl    (l_fl),
			.right_val  (r_val),
			.right_age  (r_age),
			.right_fl   (r_fl),
			.val_q      (val_a[k]),
			.age_q      (age_a[k]),
			.fl         (fl_a[k])
		);
	end

	swm_pick #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.CNT_W        (CNT_W)
	) u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.vals      (val_a),
		.n_eff     (n_eff),
		.load      (out_load),
		.out_ready (medians.ready),
		.load_ok   (load_ok),
		.out_valid (medians.valid),
		.out_data  (medians.twice_median)
	);

	// Fill count never passes the window size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= n_eff)
		else $error("fill count above window size");

	// At most one entry leaves the window per sample
	a_one_evict: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(del_vec))
		else $error("more than one entry evicted");

	// A new result only follows an owed result
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(medians.valid) |-> $past(pend_q))
		else $error("result appeared without a pending sample");

	// A full window always finds its oldest entry
	a_evict_found: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && evict) |-> (del_vec != '0))
		else $error("oldest entry not found in a full window");

endmodule

// ----- tb/tb.sv -----
// Testbench for the sliding window median filter: scoreboard, sample driver and result checks.
`timescale 1ns / 100ps

import swm_pkg::*;

class median_scoreboard;
	typedef logic signed [SAMPLE_WIDTH_DEF-1:0] sample_t;
	typedef logic signed [SAMPLE_WIDTH_DEF:0]   median_t;

	sample_t     window_arrivals[$];
	sample_t     window_sorted[$];
	median_t     medians_due[$];
	int unsigned span;
	int          errors;

	// Map the raw setting onto the window the block really uses
	static function int unsigned clamp_size(logic [CFG_WIDTH-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > WINDOW_MAX_DEF)
			return WINDOW_MAX_DEF;
		return int'(raw);
	endfunction

	function new();
		span   = clamp_size(WINDOW_SIZE_RST);
		errors = 0;
	endfunction

	// Take a new window size and empty the window
	function void note_window(logic [CFG_WIDTH-1:0] raw);
		span = clamp_size(raw);
		window_arrivals.delete();
		window_sorted.delete();
	endfunction

	function int pending();
		return medians_due.size();
	endfunction

	// Advance the window by one accepted request and queue its median if full
	function void note_sample(sample_t v);
		sample_t     oldest;
		median_t     lo;
		median_t     hi;
		int unsigned pos;
		if (window_arrivals.size() == span) begin
			oldest = window_arrivals.pop_front();
			pos = 0;
			while (window_sorted[pos] != oldest)
				pos++;
			window_sorted.delete(pos);
		end
		window_arrivals.insert(window_arrivals.size(), v);
		// place the sample after any equal entries
		pos = 0;
		while (pos < window_sorted.size() && window_sorted[pos] <= v)
			pos++;
		window_sorted.insert(pos, v);
		if (window_sorted.size() == span) begin
			lo = median_t'(window_sorted[(span - 1) / 2]);
			hi = median_t'(window_sorted[span / 2]);
			medians_due.insert(medians_due.size(), lo + hi);
		end
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 20)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Compare one result with the oldest expectation
	task check_median(median_t got);
		median_t want;
		if (medians_due.size() == 0) begin
			report($sformatf("unexpected median %0d", got));
		end else begin
			want = medians_due.pop_front();
			if (got !== want)
				report($sformatf("twice_median got %0d, expected %0d", got, want));
		end
	endtask

	task flag_leftovers();
		while (medians_due.size() != 0)
			report($sformatf("median %0d never arrived", medians_due.pop_front()));
	endtask
endclass

module tb;
	localparam int SW         = SAMPLE_WIDTH_DEF;
	localparam int HOLD_LONG  = 200;
	localparam int SETTLE     = 4;
	localparam int ITEM_GOAL  = 550;

	typedef logic signed [SW-1:0] sample_t;

	logic clk;
	logic arst_n;

	swm_cfg_if                       setup_ch ();
	swm_sample_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
	swm_median_if #(.SAMPLE_WIDTH(SW)) median_ch ();

	median_scoreboard sb = new();

	int burst_left;
	int items_sent;
	bit hold_request;

	sliding_window_median u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.setup  (setup_ch),
		.samples(sample_ch),
		.medians(median_ch)
	);

	// Free-running clock
	always #10 clk = ~clk;

	// Check every result taken by the receiver
	always @(posedge clk) begin
		if (arst_n && median_ch.valid && median_ch.ready)
			sb.check_median(median_ch.twice_median);
	end

	// Stall the receiver on a segmented pattern, with one long hold on demand
	initial begin
		int mode;
		int seg;
		int tick;
		median_ch.ready <= 1'b0;
		tick = 0;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				median_ch.ready <= 1'b0;
				repeat (HOLD_LONG) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(1, 40);
			repeat (seg) begin
				case (mode)
					0: median_ch.ready <= 1'b1;
					1: median_ch.ready <= 1'($urandom_range(0, 1));
					2: median_ch.ready <= ($urandom_range(0, 3) == 0);
					default: median_ch.ready <= (tick % 3 == 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	// Bias towards extremes and small values so that duplicates occur
	function automatic sample_t pick_sample();
		int k;
		case ($urandom_range(0, 9))
			0: return sample_t'(16'sh7fff);
			1: return sample_t'(16'sh8000);
			2, 3: begin
				k = $urandom_range(0, 8);
				return sample_t'(k - 4);
			end
			default: return sample_t'($urandom());
		endcase
	endfunction

	// Offer one sample in bursts separated by random gaps
	task automatic send_sample(sample_t v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= v;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		burst_left--;
		items_sent++;
		sb.note_sample(v);
	endtask

	// Drop valid and hold until every result is out and the pipe has settled
	task automatic drain();
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the window size once the block is idle
	task automatic write_window(logic [CFG_WIDTH-1:0] raw);
		drain();
		setup_ch.valid       <= 1'b1;
		setup_ch.window_size <= raw;
		do
			@(posedge clk);
		while (!setup_ch.ready);
		setup_ch.valid <= 1'b0;
		sb.note_window(raw);
	endtask

	task automatic run_phase(logic [CFG_WIDTH-1:0] raw, bit long_hold);
		int count;
		write_window(raw);
		if (long_hold)
			hold_request = 1'b1;
		count = sb.clamp_size(raw) + $urandom_range(20, 45);
		repeat (count) send_sample(pick_sample());
	endtask

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		sample_t                directed[] = '{
			16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000,
			16'sd0, -16'sd1, 16'sd1,
			16'sd5, 16'sd5, -16'sd7, 16'sd5,
			16'sd100, -16'sd100, 16'sd0,
			16'sh7fff, 16'sh8000, 16'sd0, 16'sh8000
		};
		logic [CFG_WIDTH-1:0] sizes[] = '{
			6'd0, 6'd1, 6'd2, 6'd32, 6'd63, 6'd4, 6'd33, 6'd31, 6'd7, 6'd16, 6'd3
		};
		clk                  = 1'b0;
		arst_n               = 1'b0;
		setup_ch.valid       = 1'b0;
		setup_ch.window_size = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.sample     = '0;
		burst_left           = 0;
		items_sent           = 0;
		hold_request         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes and duplicates at the reset window of three
		foreach (directed[i])
			send_sample(directed[i]);

		// Sweep the settings, holding the receiver off during the window of four
		foreach (sizes[i])
			run_phase(sizes[i], sizes[i] == 6'd4);
		while (items_sent < ITEM_GOAL)
			run_phase(CFG_WIDTH'($urandom_range(0, 63)), 1'b0);

		drain();
		repeat (8) @(posedge clk);
		sb.flag_leftovers();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
